### rtl/core/ofgc_pkg.sv
`default_nettype none
package ofgc_pkg;

  localparam int GRID_MAX_DEF    = 128;
  localparam int NUM_FIELDS_DEF  = 3;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int POS_W   = 7;
  localparam int CONC_W  = 16;
  localparam int DIM_W   = 8;
  localparam int SHIFT_W = 3;
  localparam int THR_W   = 35;
  localparam int CLS_W   = 3;
  localparam int LVL_W   = 3;
  localparam int IDX_W   = 17;
  localparam int SAT_W   = 21;
  localparam int SQ_W    = 2 * SAT_W;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int REG_W   = 3;

  localparam logic [REG_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [REG_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [REG_W-1:0] REG_BLOCK_SHIFT = 3'd2;
  localparam logic [REG_W-1:0] REG_BLOCKS_ROW  = 3'd3;
  localparam logic [REG_W-1:0] REG_ZERO_THR    = 3'd4;

  localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 8'd128;
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 3'd0;
  localparam logic [DIM_W-1:0]   BLOCKS_ROW_RST  = 8'd128;
  localparam logic [THR_W-1:0]   ZERO_THR_RST    = 35'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CLS_W-1:0] CLS_RIGHT = 3'd0;
  localparam logic [CLS_W-1:0] CLS_UP    = 3'd1;
  localparam logic [CLS_W-1:0] CLS_LEFT  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_DOWN  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_ZERO  = 3'd4;

  // odor level limits in raw Q10.6: 0.1, 10, 50, 80
  localparam logic [31:0] ODOR_LIM0 = 32'd7;
  localparam logic [31:0] ODOR_LIM1 = 32'd640;
  localparam logic [31:0] ODOR_LIM2 = 32'd3200;
  localparam logic [31:0] ODOR_LIM3 = 32'd5120;

  typedef struct packed {
    logic valid;
    logic is_query;
    logic x_first;
    logic x_last;
    logic y_first;
    logic y_last;
  } ofgc_ctl_t;

endpackage
`default_nettype wire

### rtl/core/ofgc_regs.sv
`default_nettype none
module ofgc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ofgc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ofgc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ofgc_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output logic      [ofgc_pkg::DIM_W-1:0]    grid_width,
  output logic      [ofgc_pkg::DIM_W-1:0]    grid_height,
  output logic      [ofgc_pkg::SHIFT_W-1:0]  block_shift,
  output logic      [ofgc_pkg::DIM_W-1:0]    blocks_per_row,
  output logic      [ofgc_pkg::THR_W-1:0]    zero_threshold
);
  import ofgc_pkg::*;

  logic             wr;
  logic [REG_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[PADDR_W-1:PADDR_W-REG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= GRID_WIDTH_RST;
      grid_height    <= GRID_HEIGHT_RST;
      block_shift    <= BLOCK_SHIFT_RST;
      blocks_per_row <= BLOCKS_ROW_RST;
      zero_threshold <= ZERO_THR_RST;
    end else if (wr) begin
      case (reg_sel)
        REG_GRID_WIDTH:  grid_width     <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height    <= pwdata[DIM_W-1:0];
        REG_BLOCK_SHIFT: block_shift    <= pwdata[SHIFT_W-1:0];
        REG_BLOCKS_ROW:  blocks_per_row <= pwdata[DIM_W-1:0];
        REG_ZERO_THR:    zero_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height);
      REG_BLOCK_SHIFT: prdata = PDATA_W'(block_shift);
      REG_BLOCKS_ROW:  prdata = PDATA_W'(blocks_per_row);
      REG_ZERO_THR:    prdata = PDATA_W'(zero_threshold);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/ofgc_store.sv
`default_nettype none
module ofgc_store #(
  parameter  int DEPTH    = 4,
  parameter  int SAMPLE_W = 16,
  localparam int ADDR_W   = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   addr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### rtl/core/ofgc_seq.sv
`default_nettype none
module ofgc_seq #(
  parameter  int GRID_MAX   = 128,
  parameter  int NUM_FIELDS = 3,
  parameter  int SAMPLE_W   = 16,
  parameter  int COORD_W    = 8,
  localparam int DEPTH      = NUM_FIELDS * GRID_MAX * GRID_MAX,
  localparam int ADDR_W     = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op,
  input  wire logic [1:0]                    field_sel,
  input  wire logic [ofgc_pkg::POS_W-1:0]    pos_x,
  input  wire logic [ofgc_pkg::POS_W-1:0]    pos_y,
  input  wire logic [ofgc_pkg::CONC_W-1:0]   conc_value,
  input  wire logic [ofgc_pkg::DIM_W-1:0]    grid_width,
  input  wire logic [ofgc_pkg::DIM_W-1:0]    grid_height,
  input  wire logic [ofgc_pkg::SHIFT_W-1:0]  block_shift,
  output logic                               mem_we,
  output logic      [ADDR_W-1:0]             mem_addr,
  output logic      [SAMPLE_W-1:0]           mem_wdata,
  input  wire logic [SAMPLE_W-1:0]           mem_rdata,
  output ofgc_pkg::ofgc_ctl_t                g_ctl,
  output logic      [SAMPLE_W-1:0]           g_here,
  output logic      [SAMPLE_W-1:0]           g_left,
  output logic      [SAMPLE_W-1:0]           g_right,
  output logic      [SAMPLE_W-1:0]           g_down,
  output logic      [SAMPLE_W-1:0]           g_up,
  output logic      [COORD_W-1:0]            g_bx,
  output logic      [COORD_W-1:0]            g_by
);
  import ofgc_pkg::*;

  localparam int CELLS = GRID_MAX * GRID_MAX;

  localparam logic [2:0] STEP_HERE  = 3'd0;
  localparam logic [2:0] STEP_LEFT  = 3'd1;
  localparam logic [2:0] STEP_RIGHT = 3'd2;
  localparam logic [2:0] STEP_DOWN  = 3'd3;
  localparam logic [2:0] STEP_UP    = 3'd4;

  logic                accept;
  logic                active;
  logic [2:0]          step;
  logic                last;

  logic                op_q;
  logic                wr_ok_q;
  logic [ADDR_W-1:0]   base_q;
  logic [COORD_W-1:0]  x_q;
  logic [COORD_W-1:0]  y_q;
  logic [SAMPLE_W-1:0] val_q;
  ofgc_ctl_t           flags_q;
  ofgc_ctl_t           flags_d;
  logic [COORD_W-1:0]  bx_d;
  logic [COORD_W-1:0]  by_d;

  logic                rd_pend;
  logic [2:0]          rd_step;
  logic                ack_pend;
  logic [SAMPLE_W-1:0] here_c;
  logic [SAMPLE_W-1:0] left_c;
  logic [SAMPLE_W-1:0] right_c;
  logic [SAMPLE_W-1:0] down_c;

  logic [COORD_W-1:0]  w_eff;
  logic [COORD_W-1:0]  h_eff;
  logic [COORD_W-1:0]  px;
  logic [COORD_W-1:0]  py;
  logic [COORD_W-1:0]  xs;
  logic [COORD_W-1:0]  ys;
  logic [ADDR_W-1:0]   base_next;
  ofgc_ctl_t           flags_next;
  logic [COORD_W-1:0]  xx;
  logic [COORD_W-1:0]  yy;

  assign accept = start && !busy;
  assign last   = (op_q == OP_WRITE) || (step == STEP_UP);
  assign busy   = active && !last;

  always_comb begin
    px = COORD_W'(pos_x);
    py = COORD_W'(pos_y);
    if (COORD_W'(grid_width) < COORD_W'(2)) begin
      w_eff = COORD_W'(2);
    end else if (COORD_W'(grid_width) > COORD_W'(GRID_MAX)) begin
      w_eff = COORD_W'(GRID_MAX);
    end else begin
      w_eff = COORD_W'(grid_width);
    end
    if (COORD_W'(grid_height) < COORD_W'(2)) begin
      h_eff = COORD_W'(2);
    end else if (COORD_W'(grid_height) > COORD_W'(GRID_MAX)) begin
      h_eff = COORD_W'(GRID_MAX);
    end else begin
      h_eff = COORD_W'(grid_height);
    end
    xs = (px >= w_eff) ? w_eff - COORD_W'(1) : px;
    ys = (py >= h_eff) ? h_eff - COORD_W'(1) : py;
    if (32'(field_sel) < 32'(NUM_FIELDS)) begin
      base_next = ADDR_W'(field_sel) * ADDR_W'(CELLS);
    end else begin
      base_next = ADDR_W'(NUM_FIELDS - 1) * ADDR_W'(CELLS);
    end
    flags_next          = '0;
    flags_next.is_query = op;
    flags_next.x_first  = (xs == '0);
    flags_next.x_last   = (xs + COORD_W'(1) == w_eff);
    flags_next.y_first  = (ys == '0);
    flags_next.y_last   = (ys + COORD_W'(1) == h_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      step     <= STEP_HERE;
      rd_pend  <= 1'b0;
      ack_pend <= 1'b0;
    end else begin
      if (accept) begin
        active <= 1'b1;
        step   <= STEP_HERE;
      end else if (active) begin
        if (last) begin
          active <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end
      rd_pend  <= active && (op_q == OP_QUERY);
      ack_pend <= active && (op_q == OP_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      base_q  <= base_next;
      x_q     <= (op == OP_QUERY) ? xs : px;
      y_q     <= (op == OP_QUERY) ? ys : py;
      wr_ok_q <= (px < COORD_W'(GRID_MAX)) && (py < COORD_W'(GRID_MAX));
      val_q   <= SAMPLE_W'(conc_value);
      flags_q <= flags_next;
    end
    if (active && last) begin
      flags_d <= flags_q;
      bx_d    <= x_q >> block_shift;
      by_d    <= y_q >> block_shift;
    end
    rd_step <= step;
    if (rd_pend) begin
      case (rd_step)
        STEP_HERE:  here_c  <= mem_rdata;
        STEP_LEFT:  left_c  <= mem_rdata;
        STEP_RIGHT: right_c <= mem_rdata;
        STEP_DOWN:  down_c  <= mem_rdata;
        default: ;
      endcase
    end
  end

  // neighbor address for this step; an edge neighbor falls back to the center
  always_comb begin
    case (step)
      STEP_HERE: begin
        xx = x_q;
        yy = y_q;
      end
      STEP_LEFT: begin
        xx = flags_q.x_first ? x_q : x_q - COORD_W'(1);
        yy = y_q;
      end
      STEP_RIGHT: begin
        xx = flags_q.x_last ? x_q : x_q + COORD_W'(1);
        yy = y_q;
      end
      STEP_DOWN: begin
        xx = x_q;
        yy = flags_q.y_first ? y_q : y_q - COORD_W'(1);
      end
      STEP_UP: begin
        xx = x_q;
        yy = flags_q.y_last ? y_q : y_q + COORD_W'(1);
      end
      default: begin
        xx = x_q;
        yy = y_q;
      end
    endcase
  end

  assign mem_addr  = base_q + ADDR_W'(yy) * ADDR_W'(GRID_MAX) + ADDR_W'(xx);
  assign mem_we    = active && (op_q == OP_WRITE) && wr_ok_q;
  assign mem_wdata = val_q;

  always_comb begin
    g_ctl          = flags_d;
    g_ctl.valid    = (rd_pend && (rd_step == STEP_UP)) || ack_pend;
    g_ctl.is_query = rd_pend;
  end

  assign g_here  = here_c;
  assign g_left  = left_c;
  assign g_right = right_c;
  assign g_down  = down_c;
  assign g_up    = mem_rdata;
  assign g_bx    = bx_d;
  assign g_by    = by_d;

`ifndef NO_ASSERTIONS
  a_query_gather: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_QUERY)) |-> ##6 (g_ctl.valid && g_ctl.is_query))
    else $error("query item did not complete its five reads");
  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_WRITE)) |-> ##2 (g_ctl.valid && !g_ctl.is_query))
    else $error("write item not acknowledged");
  a_we_no_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !rd_pend)
    else $error("memory write overlapped a query read");
`endif

endmodule
`default_nettype wire

### rtl/core/ofgc_eval.sv
`default_nettype none
module ofgc_eval #(
  parameter int SAMPLE_W = 16,
  parameter int COORD_W  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ofgc_pkg::ofgc_ctl_t           ctl_in,
  input  wire logic [SAMPLE_W-1:0]           here,
  input  wire logic [SAMPLE_W-1:0]           left,
  input  wire logic [SAMPLE_W-1:0]           right,
  input  wire logic [SAMPLE_W-1:0]           down,
  input  wire logic [SAMPLE_W-1:0]           up,
  input  wire logic [COORD_W-1:0]            bx,
  input  wire logic [COORD_W-1:0]            by,
  input  wire logic [ofgc_pkg::DIM_W-1:0]    blocks_per_row,
  input  wire logic [ofgc_pkg::THR_W-1:0]    zero_threshold,
  output logic                               done,
  output logic      [ofgc_pkg::CLS_W-1:0]    grad_class,
  output logic      [ofgc_pkg::LVL_W-1:0]    scent_level,
  output logic      [ofgc_pkg::IDX_W-1:0]    state_index,
  output logic                               is_query
);
  import ofgc_pkg::*;

  localparam int GW = SAMPLE_W + 2;
  localparam int EW = (GW > SAT_W) ? GW : SAT_W;
  localparam int PW = DIM_W + COORD_W;
  localparam int BW = PW + 1;
  localparam int IW = BW + 3;

  ofgc_ctl_t           s1_ctl;
  logic [GW-1:0]       gx1;
  logic [GW-1:0]       gy1;
  logic [SAMPLE_W-1:0] here1;
  logic [COORD_W-1:0]  bx1;
  logic [COORD_W-1:0]  by1;

  ofgc_ctl_t           s2_ctl;
  logic [SAT_W-1:0]    ax2;
  logic [SAT_W-1:0]    ay2;
  logic                xpos2;
  logic                ypos2;
  logic [LVL_W-1:0]    lvl2;
  logic [PW-1:0]       prod2;
  logic [COORD_W-1:0]  bx2;

  ofgc_ctl_t           s3_ctl;
  logic [SQ_W-1:0]     sqx3;
  logic [SQ_W-1:0]     sqy3;
  logic                xdom3;
  logic                xpos3;
  logic                ypos3;
  logic [LVL_W-1:0]    lvl3;
  logic [BW-1:0]       blk3;

  logic [GW-1:0]       gx_next;
  logic [GW-1:0]       gy_next;
  logic [GW-1:0]       absx;
  logic [GW-1:0]       absy;
  logic [EW-1:0]       absx_e;
  logic [EW-1:0]       absy_e;
  logic [SAT_W-1:0]    ax_next;
  logic [SAT_W-1:0]    ay_next;
  logic [LVL_W-1:0]    lvl_next;
  logic [SQ_W:0]       mag;
  logic [CLS_W-1:0]    cls_next;
  logic [IW-1:0]       idx_next;

  // gradients at twice scale: one-sided at the edges, central inside
  always_comb begin
    if (ctl_in.x_first) begin
      gx_next = (GW'(right) - GW'(here)) << 1;
    end else if (ctl_in.x_last) begin
      gx_next = (GW'(here) - GW'(left)) << 1;
    end else begin
      gx_next = GW'(right) - GW'(left);
    end
    if (ctl_in.y_first) begin
      gy_next = (GW'(up) - GW'(here)) << 1;
    end else if (ctl_in.y_last) begin
      gy_next = (GW'(here) - GW'(down)) << 1;
    end else begin
      gy_next = GW'(up) - GW'(down);
    end
  end

  always_comb begin
    absx    = gx1[GW-1] ? (~gx1 + GW'(1)) : gx1;
    absy    = gy1[GW-1] ? (~gy1 + GW'(1)) : gy1;
    absx_e  = EW'(absx);
    absy_e  = EW'(absy);
    ax_next = (absx_e > (EW'(1) << (SAT_W - 1))) ? (SAT_W'(1) << (SAT_W - 1))
                                                  : absx_e[SAT_W-1:0];
    ay_next = (absy_e > (EW'(1) << (SAT_W - 1))) ? (SAT_W'(1) << (SAT_W - 1))
                                                  : absy_e[SAT_W-1:0];
    if (32'(here1) < ODOR_LIM0) begin
      lvl_next = 3'd0;
    end else if (32'(here1) < ODOR_LIM1) begin
      lvl_next = 3'd1;
    end else if (32'(here1) < ODOR_LIM2) begin
      lvl_next = 3'd2;
    end else if (32'(here1) < ODOR_LIM3) begin
      lvl_next = 3'd3;
    end else begin
      lvl_next = 3'd4;
    end
  end

  always_comb begin
    mag = (SQ_W + 1)'(sqx3) + (SQ_W + 1)'(sqy3);
    if (mag < (SQ_W + 1)'(zero_threshold)) begin
      cls_next = CLS_ZERO;
    end else if (xdom3) begin
      cls_next = xpos3 ? CLS_RIGHT : CLS_LEFT;
    end else begin
      cls_next = ypos3 ? CLS_UP : CLS_DOWN;
    end
    idx_next = IW'(lvl3) + (IW'(blk3) << 2) + IW'(blk3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
      done   <= 1'b0;
    end else begin
      s1_ctl <= ctl_in;
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
      done   <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    gx1   <= gx_next;
    gy1   <= gy_next;
    here1 <= here;
    bx1   <= bx;
    by1   <= by;

    ax2   <= ax_next;
    ay2   <= ay_next;
    xpos2 <= !gx1[GW-1] && (gx1 != '0);
    ypos2 <= !gy1[GW-1] && (gy1 != '0);
    lvl2  <= lvl_next;
    prod2 <= PW'(blocks_per_row) * PW'(by1);
    bx2   <= bx1;

    sqx3  <= SQ_W'(ax2) * SQ_W'(ax2);
    sqy3  <= SQ_W'(ay2) * SQ_W'(ay2);
    xdom3 <= ax2 > ay2;
    xpos3 <= xpos2;
    ypos3 <= ypos2;
    lvl3  <= lvl2;
    blk3  <= BW'(bx2) + BW'(prod2);

    is_query <= s3_ctl.is_query;
    if (s3_ctl.is_query) begin
      grad_class  <= cls_next;
      scent_level <= lvl3;
      state_index <= idx_next[IDX_W-1:0];
    end else begin
      grad_class  <= '0;
      scent_level <= '0;
      state_index <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    ctl_in.valid |-> ##4 done)
    else $error("result strobe missing four cycles after gather");
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !is_query) |-> (grad_class == '0 && state_index == '0))
    else $error("write acknowledge carries nonzero fields");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl_in.valid, 4))
    else $error("result strobe without a gathered item");
`endif

endmodule
`default_nettype wire

### rtl/core/odor_field_gradient_classifier.sv
`default_nettype none
// Query item: five single-port grid memory reads, one per cycle; busy is high
// through the center, left, right and down reads; the next item is taken with
// the up read. done pulses after the eval stages. Write item: taken every cycle
// unless a query holds busy; acknowledged by done. Results keep item order, no stall.
// Synchronous reset clears control state and config registers; grid memory
// is not cleared and a cell holds no defined value until written.
module odor_field_gradient_classifier #(
  parameter int GRID_MAX    = ofgc_pkg::GRID_MAX_DEF,
  parameter int NUM_FIELDS  = ofgc_pkg::NUM_FIELDS_DEF,
  parameter int SAMPLE_BITS = ofgc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ofgc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ofgc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ofgc_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op,
  input  wire logic [1:0]                    field_sel,
  input  wire logic [ofgc_pkg::POS_W-1:0]    pos_x,
  input  wire logic [ofgc_pkg::POS_W-1:0]    pos_y,
  input  wire logic [ofgc_pkg::CONC_W-1:0]   conc_value,
  output logic                               done,
  output logic      [ofgc_pkg::CLS_W-1:0]    grad_class,
  output logic      [ofgc_pkg::LVL_W-1:0]    scent_level,
  output logic      [ofgc_pkg::IDX_W-1:0]    state_index,
  output logic                               is_query
);
  import ofgc_pkg::*;

  localparam int DEPTH   = NUM_FIELDS * GRID_MAX * GRID_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COORD_W = ($clog2(GRID_MAX + 1) > DIM_W) ? $clog2(GRID_MAX + 1) : DIM_W;

  logic [DIM_W-1:0]       grid_width;
  logic [DIM_W-1:0]       grid_height;
  logic [SHIFT_W-1:0]     block_shift;
  logic [DIM_W-1:0]       blocks_per_row;
  logic [THR_W-1:0]       zero_threshold;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  ofgc_ctl_t              g_ctl;
  logic [SAMPLE_BITS-1:0] g_here;
  logic [SAMPLE_BITS-1:0] g_left;
  logic [SAMPLE_BITS-1:0] g_right;
  logic [SAMPLE_BITS-1:0] g_down;
  logic [SAMPLE_BITS-1:0] g_up;
  logic [COORD_W-1:0]     g_bx;
  logic [COORD_W-1:0]     g_by;

  ofgc_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .grid_width     (grid_width),
    .grid_height    (grid_height),
    .block_shift    (block_shift),
    .blocks_per_row (blocks_per_row),
    .zero_threshold (zero_threshold)
  );

  ofgc_store #(
    .DEPTH    (DEPTH),
    .SAMPLE_W (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ofgc_seq #(
    .GRID_MAX   (GRID_MAX),
    .NUM_FIELDS (NUM_FIELDS),
    .SAMPLE_W   (SAMPLE_BITS),
    .COORD_W    (COORD_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .field_sel   (field_sel),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .conc_value  (conc_value),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .block_shift (block_shift),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .g_ctl       (g_ctl),
    .g_here      (g_here),
    .g_left      (g_left),
    .g_right     (g_right),
    .g_down      (g_down),
    .g_up        (g_up),
    .g_bx        (g_bx),
    .g_by        (g_by)
  );

  ofgc_eval #(
    .SAMPLE_W (SAMPLE_BITS),
    .COORD_W  (COORD_W)
  ) u_eval (
    .clk            (clk),
    .rst            (rst),
    .ctl_in         (g_ctl),
    .here           (g_here),
    .left           (g_left),
    .right          (g_right),
    .down           (g_down),
    .up             (g_up),
    .bx             (g_bx),
    .by             (g_by),
    .blocks_per_row (blocks_per_row),
    .zero_threshold (zero_threshold),
    .done           (done),
    .grad_class     (grad_class),
    .scent_level    (scent_level),
    .state_index    (state_index),
    .is_query       (is_query)
  );

endmodule
`default_nettype wire

### bench/odor_field_gradient_classifier_test.sv
`timescale 1ns / 1ps
module odor_field_gradient_classifier_test;
  import ofgc_pkg::*;

  localparam int GRID_CELLS = GRID_MAX_DEF * GRID_MAX_DEF;
  localparam int STORE_CELLS = NUM_FIELDS_DEF * GRID_CELLS;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 205;
  localparam longint GRAD_LIMIT = 64'd1 << 20;
  localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

  typedef struct packed {
    logic              op;
    logic [1:0]        sel;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [CONC_W-1:0] conc;
  } cell_cmd_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] idx;
    logic             query;
  } cell_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;
  logic               start = 1'b0;
  wire                busy;
  wire                op;
  wire  [1:0]         field_sel;
  wire  [POS_W-1:0]   pos_x;
  wire  [POS_W-1:0]   pos_y;
  wire  [CONC_W-1:0]  conc_value;
  wire                done;
  wire  [CLS_W-1:0]   grad_class;
  wire  [LVL_W-1:0]   scent_level;
  wire  [IDX_W-1:0]   state_index;
  wire                is_query;

  cell_cmd_t    drive_cmd = '0;
  cell_cmd_t    cmd_q[$];
  cell_answer_t answer_q[$];
  logic         took = 1'b0;
  int           gap_left = 0;
  bit           idle_on = 1'b1;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  queued = 0;

  logic [DIM_W-1:0]   cfg_width = GRID_WIDTH_RST;
  logic [DIM_W-1:0]   cfg_height = GRID_HEIGHT_RST;
  logic [SHIFT_W-1:0] cfg_shift = BLOCK_SHIFT_RST;
  logic [DIM_W-1:0]   cfg_bpr = BLOCKS_ROW_RST;
  logic [THR_W-1:0]   cfg_thr = ZERO_THR_RST;

  logic [CONC_W-1:0] conc_mirror [STORE_CELLS];
  bit                planned [STORE_CELLS];

  assign op = drive_cmd.op;
  assign field_sel = drive_cmd.sel;
  assign pos_x = drive_cmd.x;
  assign pos_y = drive_cmd.y;
  assign conc_value = drive_cmd.conc;

  odor_field_gradient_classifier i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v < 2) return 2;
    if (v > GRID_MAX_DEF) return GRID_MAX_DEF;
    return v;
  endfunction

  function automatic int unsigned grid_of(logic [1:0] sel);
    return (sel >= NUM_FIELDS_DEF) ? NUM_FIELDS_DEF - 1 : sel;
  endfunction

  function automatic longint slope2(int unsigned p, int unsigned len,
                                    longint lo, longint mid, longint hi);
    if (p == 0) return 2 * (hi - mid);
    if (p + 1 < len) return hi - lo;
    return 2 * (mid - lo);
  endfunction

  // updates the cell mirror on a write, classifies the cell on a query
  function automatic cell_answer_t classify_cell(cell_cmd_t c);
    cell_answer_t    a;
    int unsigned     base, w, h, x, y, row;
    longint          here, xl, xr, yd, yu, gx, gy, ax, ay;
    longint unsigned mag, blk;
    a = '0;
    base = grid_of(c.sel) * GRID_CELLS;
    if (c.op == OP_WRITE) begin
      conc_mirror[base + c.y * GRID_MAX_DEF + c.x] = c.conc;
      return a;
    end
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    x = (c.x >= w) ? w - 1 : c.x;
    y = (c.y >= h) ? h - 1 : c.y;
    row = base + y * GRID_MAX_DEF;
    here = conc_mirror[row + x];
    xl = (x > 0) ? longint'(conc_mirror[row + x - 1]) : 0;
    xr = (x + 1 < w) ? longint'(conc_mirror[row + x + 1]) : 0;
    yd = (y > 0) ? longint'(conc_mirror[row - GRID_MAX_DEF + x]) : 0;
    yu = (y + 1 < h) ? longint'(conc_mirror[row + GRID_MAX_DEF + x]) : 0;
    gx = slope2(x, w, xl, here, xr);
    gy = slope2(y, h, yd, here, yu);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    if (ax > GRAD_LIMIT) ax = GRAD_LIMIT;
    if (ay > GRAD_LIMIT) ay = GRAD_LIMIT;
    mag = ax * ax + ay * ay;
    if (mag < cfg_thr) a.cls = CLS_ZERO;
    else if (ax > ay) a.cls = (gx > 0) ? CLS_RIGHT : CLS_LEFT;
    else a.cls = (gy > 0) ? CLS_UP : CLS_DOWN;
    if (here < ODOR_LIM0) a.lvl = 3'd0;
    else if (here < ODOR_LIM1) a.lvl = 3'd1;
    else if (here < ODOR_LIM2) a.lvl = 3'd2;
    else if (here < ODOR_LIM3) a.lvl = 3'd3;
    else a.lvl = 3'd4;
    blk = (x >> cfg_shift) + cfg_bpr * (y >> cfg_shift);
    a.idx = IDX_W'(a.lvl + 5 * blk);
    a.query = 1'b1;
    return a;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    cell_answer_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $error("result with no item outstanding: grad_class %0d is_query %0d",
               grad_class, is_query);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (grad_class !== want.cls) begin
          $error("grad_class: expected %0d, actual %0d", want.cls, grad_class);
          fail_count++;
        end
        if (scent_level !== want.lvl) begin
          $error("scent_level: expected %0d, actual %0d", want.lvl, scent_level);
          fail_count++;
        end
        if (state_index !== want.idx) begin
          $error("state_index: expected %0d, actual %0d", want.idx, state_index);
          fail_count++;
        end
        if (is_query !== want.query) begin
          $error("is_query: expected %0d, actual %0d", want.query, is_query);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) answer_q.push_back(classify_cell(drive_cmd));
    took <= !rst && start && !busy;
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() > 0) begin
        drive_cmd <= cmd_q.pop_front();
        start <= 1'b1;
        gap_left <= (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic put_cmd(logic o, int unsigned s, int unsigned x, int unsigned y,
                         int unsigned v);
    cell_cmd_t c;
    c.op = o;
    c.sel = 2'(s);
    c.x = POS_W'(x);
    c.y = POS_W'(y);
    c.conc = CONC_W'(v);
    cmd_q.push_back(c);
    if (o == OP_WRITE) planned[grid_of(c.sel) * GRID_CELLS + y * GRID_MAX_DEF + x] = 1'b1;
    queued++;
  endtask

  function automatic logic [CONC_W-1:0] pick_conc();
    int unsigned k;
    logic [31:0] lim;
    k = $urandom_range(0, 3);
    lim = (k == 0) ? ODOR_LIM0 : (k == 1) ? ODOR_LIM1 : (k == 2) ? ODOR_LIM2 : ODOR_LIM3;
    case ($urandom_range(0, 4))
      0: return CONC_W'($urandom_range(0, 16));
      1: return CONC_W'(lim - $urandom_range(0, 1));
      2: return CONC_W'($urandom_range(0, 6000));
      3: return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
      default: return CONC_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_pos(int unsigned dim);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return dim - 1 - $urandom_range(0, (dim > 4) ? 3 : dim - 1);
      2: return $urandom_range(0, GRID_MAX_DEF - 1);
      default: return $urandom_range(0, dim - 1);
    endcase
  endfunction

  task automatic cover_cell(logic [1:0] s, int x, int y);
    if (x < 0 || y < 0 || x >= GRID_MAX_DEF || y >= GRID_MAX_DEF) return;
    if (!planned[grid_of(s) * GRID_CELLS + y * GRID_MAX_DEF + x])
      put_cmd(OP_WRITE, s, x, y, pick_conc());
  endtask

  // writes whatever the queried cell and its neighbors still lack, sometimes rewrites the cell, then queries
  task automatic probe_sequence();
    logic [1:0]  s;
    int unsigned w, h, px, py;
    int          x, y;
    s = 2'($urandom_range(0, 3));
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    px = pick_pos(w);
    py = pick_pos(h);
    x = (px >= w) ? w - 1 : px;
    y = (py >= h) ? h - 1 : py;
    cover_cell(s, x, y);
    cover_cell(s, x - 1, y);
    cover_cell(s, x + 1, y);
    cover_cell(s, x, y - 1);
    cover_cell(s, x, y + 1);
    if ($urandom_range(0, 2) == 0) put_cmd(OP_WRITE, s, x, y, pick_conc());
    put_cmd(OP_QUERY, s, px, py, $urandom);
  endtask

  task automatic set_reg(logic [REG_W-1:0] r, logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_GRID_WIDTH:  cfg_width = DIM_W'(v);
      REG_GRID_HEIGHT: cfg_height = DIM_W'(v);
      REG_BLOCK_SHIFT: cfg_shift = SHIFT_W'(v);
      REG_BLOCKS_ROW:  cfg_bpr = DIM_W'(v);
      REG_ZERO_THR:    cfg_thr = THR_W'(v);
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned w, int unsigned h, int unsigned sh,
                         int unsigned bpr, longint unsigned thr);
    set_reg(REG_GRID_WIDTH, w);
    set_reg(REG_GRID_HEIGHT, h);
    set_reg(REG_BLOCK_SHIFT, sh);
    set_reg(REG_BLOCKS_ROW, bpr);
    set_reg(REG_ZERO_THR, thr);
  endtask

  task automatic drain();
    do @(negedge clk); while (cmd_q.size() != 0 || start || answer_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned     g;
    longint unsigned thr;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // corner, tie with zero threshold falls to down
    put_cmd(OP_WRITE, 2'd0, 0, 0, 16'hFFFF);
    put_cmd(OP_WRITE, 2'd0, 1, 0, 16'h0000);
    put_cmd(OP_WRITE, 2'd0, 0, 1, 16'h0000);
    put_cmd(OP_QUERY, 2'd0, 0, 0, $urandom);
    // out-of-range grid number maps to the last grid, far corner, max index
    put_cmd(OP_WRITE, 2'd3, 127, 127, 16'd5120);
    put_cmd(OP_WRITE, 2'd3, 126, 127, 16'd639);
    put_cmd(OP_WRITE, 2'd3, 127, 126, 16'd3200);
    put_cmd(OP_QUERY, 2'd2, 127, 127, 16'hFFFF);
    // interior: left, then up after rewriting one neighbor
    put_cmd(OP_WRITE, 2'd1, 5, 5, 16'd3199);
    put_cmd(OP_WRITE, 2'd1, 4, 5, 16'd100);
    put_cmd(OP_WRITE, 2'd1, 6, 5, 16'd0);
    put_cmd(OP_WRITE, 2'd1, 5, 4, 16'd7);
    put_cmd(OP_WRITE, 2'd1, 5, 6, 16'd6);
    put_cmd(OP_QUERY, 2'd1, 5, 5, $urandom);
    put_cmd(OP_WRITE, 2'd1, 5, 6, 16'hFFFF);
    put_cmd(OP_QUERY, 2'd1, 5, 5, $urandom);
    // flat neighborhood, zero gradient
    put_cmd(OP_WRITE, 2'd1, 20, 20, 16'd640);
    put_cmd(OP_WRITE, 2'd1, 19, 20, 16'd640);
    put_cmd(OP_WRITE, 2'd1, 21, 20, 16'd640);
    put_cmd(OP_WRITE, 2'd1, 20, 19, 16'd640);
    put_cmd(OP_WRITE, 2'd1, 20, 21, 16'd640);
    put_cmd(OP_QUERY, 2'd1, 20, 20, $urandom);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        g = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 131070);
        thr = longint'(g) * g;
        case (phase)
          1: set_all(2, 2, 0, 1, '0);
          2: set_all(255, 128, 7, 255, THR_MAX);
          3: set_all(0, 1, 0, 0, thr);
          4: set_all(128, 128, 0, 255, thr);
          default: set_all(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(2, 24),
                           ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(2, 24),
                           $urandom_range(0, 7), $urandom_range(0, 255), thr);
        endcase
      end
      idle_on = (phase < NUM_PHASES - 1);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          put_cmd(OP_WRITE, $urandom_range(0, 3), $urandom_range(0, GRID_MAX_DEF - 1),
                  $urandom_range(0, GRID_MAX_DEF - 1), $urandom);
        else
          probe_sequence();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ofgc_pkg.sv
rtl/core/ofgc_regs.sv
rtl/core/ofgc_store.sv
rtl/core/ofgc_seq.sv
rtl/core/ofgc_eval.sv
rtl/core/odor_field_gradient_classifier.sv
bench/odor_field_gradient_classifier_test.sv
